/* sv/lfsc_pkg.sv */
package lfsc_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  error_kind;
        logic [11:0] error_position;
        logic [11:0] token_count;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ATOM   = 3'd1,
        PH_BOX    = 3'd2,
        PH_LT     = 3'd3,
        PH_LTDASH = 3'd4,
        PH_DASH   = 3'd5,
        PH_BAR    = 3'd6,
        PH_AMP    = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD        = 3'd1,
        ERR_UNEXPECTED = 3'd2,
        ERR_DEPTH      = 3'd3,
        ERR_END        = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        TK_NONE,
        TK_UNARY,
        TK_BINARY,
        TK_OPEN,
        TK_CLOSE,
        TK_ATOM,
        TK_BAD
    } t_token;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;

    localparam logic [11:0] CAP12 = 12'hFFF;

endpackage

/* sv/ltl_formula_syntax_checker.sv */
// Channel   Direction  Valid    Stall    Payload
// input     in         i_valid  o_stall  i_item   (one character, last flag)
// result    out        o_valid  i_stall  o_result (verdict on the last character)
//
// One character is taken per cycle; the lexer and recognizer state update in the
// same cycle, and the verdict for a last character sits in the result register
// from the next cycle on. Input stalls only while a held result is stalled.
// Synchronous active-low reset clears the lexer, the parser state and the result
// valid. After each verdict the parser state starts over for the next formula.
module ltl_formula_syntax_checker #(
    parameter int MAX_DEPTH  = 64,
    parameter int MAX_LENGTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  lfsc_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output lfsc_pkg::t_out_item o_result
);
    import lfsc_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int POS_W   = $clog2(MAX_LENGTH);

    t_phase               r_phase,    n_phase;
    logic                 r_expect,   n_expect;
    logic [DEPTH_W-1:0]   r_depth,    n_depth;
    logic                 r_failed,   n_failed;
    t_err                 r_fkind,    n_fkind;
    logic [POS_W-1:0]     r_fpos,     n_fpos;
    logic [POS_W-1:0]     r_pos,      n_pos;
    logic [11:0]          r_tokens,   n_tokens;
    logic                 r_out_valid;
    t_out_item            r_out,      n_out;

    t_token               lx_tok;
    t_phase               lx_phase;
    logic [7:0]           ch;
    logic                 is_lower, is_digit, accept_in;
    logic [16:0]          fpos_ext;

    assign ch        = i_item.character;
    assign is_lower  = (ch >= CH_LOW_A) && (ch <= CH_LOW_Z);
    assign is_digit  = (ch >= CH_DIG_0) && (ch <= CH_DIG_9);
    assign o_stall   = r_out_valid && i_stall;
    assign accept_in = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // lexer: classify the character given the pending prefix
    always_comb begin
        lx_tok   = TK_NONE;
        lx_phase = PH_IDLE;
        unique case (r_phase)
            PH_BOX: begin
                lx_tok = (ch == CH_RBRACK) ? TK_UNARY : TK_BAD;
            end
            PH_LT: begin
                if (ch == CH_GT) begin
                    lx_tok = TK_UNARY;
                end else if (ch == CH_DASH) begin
                    lx_phase = PH_LTDASH;
                end else begin
                    lx_tok = TK_BAD;
                end
            end
            PH_LTDASH, PH_DASH: begin
                lx_tok = (ch == CH_GT) ? TK_BINARY : TK_BAD;
            end
            PH_BAR: begin
                lx_tok = (ch == CH_BAR) ? TK_BINARY : TK_BAD;
            end
            PH_AMP: begin
                lx_tok = (ch == CH_AMP) ? TK_BINARY : TK_BAD;
            end
            default: begin
                if (r_phase == PH_ATOM &&
                    (is_lower || is_digit || ch == CH_UNDER || ch == CH_EQ)) begin
                    lx_phase = PH_ATOM;
                end else begin
                    case (ch) inside
                        CH_SPACE, CH_TAB, CH_NL: lx_tok = TK_NONE;
                        CH_LPAREN:               lx_tok = TK_OPEN;
                        CH_RPAREN:               lx_tok = TK_CLOSE;
                        CH_BANG, CH_X, CH_O, CH_G, CH_F:
                                                 lx_tok = TK_UNARY;
                        CH_U, CH_W, CH_R, CH_V, CH_PLUS, CH_STAR, CH_CARET:
                                                 lx_tok = TK_BINARY;
                        CH_LBRACK:               lx_phase = PH_BOX;
                        CH_LT:                   lx_phase = PH_LT;
                        CH_DASH:                 lx_phase = PH_DASH;
                        CH_BAR:                  lx_phase = PH_BAR;
                        CH_AMP:                  lx_phase = PH_AMP;
                        default: begin
                            if (is_lower || ch == CH_UNDER) begin
                                lx_tok   = TK_ATOM;
                                lx_phase = PH_ATOM;
                            end else begin
                                lx_tok = TK_BAD;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // recognizer: apply the token, then the end check on a last character
    always_comb begin
        n_phase  = r_phase;
        n_expect = r_expect;
        n_depth  = r_depth;
        n_failed = r_failed;
        n_fkind  = r_fkind;
        n_fpos   = r_fpos;
        n_pos    = r_pos;
        n_tokens = r_tokens;
        fpos_ext = '0;
        n_out    = '0;

        if (!r_failed) begin
            n_phase = lx_phase;
            case (lx_tok)
                TK_UNARY: begin
                    if (!r_expect) begin
                        n_failed = 1'b1;
                        n_fkind  = ERR_UNEXPECTED;
                    end
                end
                TK_BINARY: begin
                    if (r_expect) begin
                        n_failed = 1'b1;
                        n_fkind  = ERR_UNEXPECTED;
                    end else begin
                        n_expect = 1'b1;
                    end
                end
                TK_OPEN: begin
                    if (!r_expect) begin
                        n_failed = 1'b1;
                        n_fkind  = ERR_UNEXPECTED;
                    end else if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                        n_failed = 1'b1;
                        n_fkind  = ERR_DEPTH;
                    end else begin
                        n_depth = r_depth + DEPTH_W'(1);
                    end
                end
                TK_CLOSE: begin
                    if (r_expect || r_depth == '0) begin
                        n_failed = 1'b1;
                        n_fkind  = ERR_UNEXPECTED;
                    end else begin
                        n_depth = r_depth - DEPTH_W'(1);
                    end
                end
                TK_ATOM: begin
                    if (!r_expect) begin
                        n_failed = 1'b1;
                        n_fkind  = ERR_UNEXPECTED;
                    end else begin
                        n_expect = 1'b0;
                    end
                end
                TK_BAD: begin
                    n_failed = 1'b1;
                    n_fkind  = ERR_BAD;
                end
                default: ;
            endcase
            if (lx_tok != TK_NONE && !n_failed && r_tokens != CAP12) begin
                n_tokens = r_tokens + 12'd1;
            end
            if (i_item.last && !n_failed) begin
                if (n_phase != PH_IDLE && n_phase != PH_ATOM) begin
                    n_failed = 1'b1;
                    n_fkind  = ERR_BAD;
                end else if (n_expect || n_depth != '0) begin
                    n_failed = 1'b1;
                    n_fkind  = ERR_END;
                end
            end
            if (n_failed) begin
                n_fpos  = r_pos;
                n_phase = PH_IDLE;
            end
        end

        fpos_ext             = 17'(n_fpos);
        n_out.accepted       = !n_failed;
        n_out.error_kind     = n_failed ? n_fkind : ERR_NONE;
        n_out.error_position = !n_failed ? 12'd0 :
                               (fpos_ext > 17'(CAP12)) ? CAP12 : fpos_ext[11:0];
        n_out.token_count    = n_tokens;

        if (i_item.last) begin
            // start over for the next formula
            n_phase  = PH_IDLE;
            n_expect = 1'b1;
            n_depth  = '0;
            n_failed = 1'b0;
            n_fkind  = ERR_NONE;
            n_fpos   = '0;
            n_pos    = '0;
            n_tokens = '0;
        end else if (r_pos != POS_W'(MAX_LENGTH - 1)) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_expect    <= 1'b1;
            r_depth     <= '0;
            r_failed    <= 1'b0;
            r_fkind     <= ERR_NONE;
            r_fpos      <= '0;
            r_pos       <= '0;
            r_tokens    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_phase  <= n_phase;
                r_expect <= n_expect;
                r_depth  <= n_depth;
                r_failed <= n_failed;
                r_fkind  <= n_fkind;
                r_fpos   <= n_fpos;
                r_pos    <= n_pos;
                r_tokens <= n_tokens;
            end
            // load a verdict, or drop the held one once transferred
            if (accept_in && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in && i_item.last) begin
            r_out <= n_out;
        end
    end

endmodule

/* test/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lfsc_pkg::*;

    localparam int DEPTH_LIMIT  = 64;
    localparam int LENGTH_LIMIT = 4096;
    localparam int RANDOM_CHARS = 1200;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        t_in_item item;
        int       gap;
        bit       drain;
    } t_char_slot;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_result;

    t_char_slot char_slots[$];
    t_out_item  verdicts_due[$];
    logic [7:0] text[$];
    t_out_item  want;
    int         errors    = 0;
    int         cycles    = 0;
    int         hold_left = 0;

    string unary_ops[7]   = '{"!", "X", "O", "G", "F", "[]", "<>"};
    string binary_ops[11] = '{"U", "W", "R", "V", "+", "*", "^", "->", "<->", "||", "&&"};
    string lex_chars      = "()!XOGFUWRV+*^[]<>-|&_=az09 \t\n";
    string directed[6]    = '{"X[]<>!(a_0=)&&z9", ")", "a<-", "a|b", "(a", " \tb\n"};

    // parser state of the formula in flight
    t_phase lex_state    = PH_IDLE;
    bit     want_operand = 1'b1;
    int     open_parens  = 0;
    bit     rejected     = 1'b0;
    t_err   reject_kind  = ERR_NONE;
    int     reject_pos   = 0;
    int     char_idx     = 0;
    int     token_total  = 0;

    ltl_formula_syntax_checker #(
        .MAX_DEPTH (DEPTH_LIMIT),
        .MAX_LENGTH(LENGTH_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(o_result)
    );

    always #6ns i_clk = ~i_clk;

    function automatic void reject(t_err kind);
        rejected    = 1'b1;
        reject_kind = kind;
        reject_pos  = char_idx;
        lex_state   = PH_IDLE;
    endfunction

    // Advance the lexer by one character and return the token it completes.
    function automatic t_token lex_step(logic [7:0] c);
        t_phase held;
        held      = lex_state;
        lex_state = PH_IDLE;
        case (held)
            PH_ATOM: begin
                if ((c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_DIG_0 && c <= CH_DIG_9) ||
                    c == CH_UNDER || c == CH_EQ) begin
                    lex_state = PH_ATOM;
                    return TK_NONE;
                end
            end
            PH_BOX: begin
                if (c == CH_RBRACK) return TK_UNARY;
                return TK_BAD;
            end
            PH_LT: begin
                if (c == CH_GT) return TK_UNARY;
                if (c == CH_DASH) begin
                    lex_state = PH_LTDASH;
                    return TK_NONE;
                end
                return TK_BAD;
            end
            PH_LTDASH, PH_DASH: begin
                if (c == CH_GT) return TK_BINARY;
                return TK_BAD;
            end
            PH_BAR: begin
                if (c == CH_BAR) return TK_BINARY;
                return TK_BAD;
            end
            PH_AMP: begin
                if (c == CH_AMP) return TK_BINARY;
                return TK_BAD;
            end
            default: ;
        endcase
        case (c)
            CH_SPACE, CH_TAB, CH_NL: return TK_NONE;
            CH_LPAREN: return TK_OPEN;
            CH_RPAREN: return TK_CLOSE;
            CH_BANG, CH_X, CH_O, CH_G, CH_F: return TK_UNARY;
            CH_U, CH_W, CH_R, CH_V, CH_PLUS, CH_STAR, CH_CARET: return TK_BINARY;
            CH_LBRACK: lex_state = PH_BOX;
            CH_LT: lex_state = PH_LT;
            CH_DASH: lex_state = PH_DASH;
            CH_BAR: lex_state = PH_BAR;
            CH_AMP: lex_state = PH_AMP;
            default: begin
                if ((c >= CH_LOW_A && c <= CH_LOW_Z) || c == CH_UNDER) return TK_ATOM;
                return TK_BAD;
            end
        endcase
        return TK_NONE;
    endfunction

    function automatic void apply_token(t_token tk);
        t_err err;
        err = ERR_NONE;
        if (tk == TK_NONE) return;
        case (tk)
            TK_UNARY, TK_ATOM: begin
                if (!want_operand) err = ERR_UNEXPECTED;
            end
            TK_BINARY: begin
                if (want_operand) err = ERR_UNEXPECTED;
            end
            TK_OPEN: begin
                if (!want_operand) err = ERR_UNEXPECTED;
                else if (open_parens >= DEPTH_LIMIT) err = ERR_DEPTH;
            end
            TK_CLOSE: begin
                if (want_operand || open_parens == 0) err = ERR_UNEXPECTED;
            end
            default: err = ERR_BAD;
        endcase
        if (err != ERR_NONE) begin
            reject(err);
        end else begin
            case (tk)
                TK_BINARY: want_operand = 1'b1;
                TK_OPEN: open_parens++;
                TK_CLOSE: open_parens--;
                TK_ATOM: begin
                    want_operand = 1'b0;
                    lex_state    = PH_ATOM;
                end
                default: ;
            endcase
            if (token_total < CAP12) token_total++;
        end
    endfunction

    function automatic void parse_char(t_in_item it);
        t_out_item verdict;
        if (!rejected) apply_token(lex_step(it.character));
        if (!it.last) begin
            if (char_idx < LENGTH_LIMIT - 1) char_idx++;
            return;
        end
        if (!rejected) begin
            if (lex_state != PH_IDLE && lex_state != PH_ATOM) reject(ERR_BAD);
            else if (want_operand || open_parens != 0) reject(ERR_END);
        end
        verdict.accepted       = !rejected;
        verdict.error_kind     = rejected ? reject_kind : ERR_NONE;
        verdict.error_position = !rejected ? 12'd0 :
                                 (reject_pos > CAP12) ? CAP12 : 12'(reject_pos);
        verdict.token_count    = (token_total > CAP12) ? CAP12 : 12'(token_total);
        verdicts_due.push_back(verdict);
        // start over for the next formula
        lex_state    = PH_IDLE;
        want_operand = 1'b1;
        open_parens  = 0;
        rejected     = 1'b0;
        reject_kind  = ERR_NONE;
        reject_pos   = 0;
        char_idx     = 0;
        token_total  = 0;
    endfunction

    function automatic void check_field(string name, int unsigned exp_val, int unsigned got);
        if (exp_val != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got);
            errors++;
        end
    endfunction

    function automatic void emit(string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endfunction

    function automatic void emit_atom();
        int pick;
        pick = $urandom_range(0, 26);
        text.push_back(pick == 26 ? CH_UNDER : 8'(CH_LOW_A + pick));
        repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(0, 38);
            if (pick < 26) text.push_back(8'(CH_LOW_A + pick));
            else if (pick < 36) text.push_back(8'(CH_DIG_0 + pick - 26));
            else if (pick == 36) text.push_back(CH_UNDER);
            else text.push_back(CH_EQ);
        end
    endfunction

    function automatic void maybe_space();
        case ($urandom_range(0, 11))
            0: text.push_back(CH_SPACE);
            1: text.push_back(CH_TAB);
            2: text.push_back(CH_NL);
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        return lex_chars[$urandom_range(0, lex_chars.len() - 1)];
    endfunction

    // Well-formed formula; deep ones open a run of parentheses around the limit.
    function automatic void build_formula();
        int  goal;
        int  cap;
        int  opened;
        int  nest;
        int  atoms;
        bit  deep;
        text.delete();
        deep   = ($urandom_range(0, 11) == 0);
        cap    = deep ? $urandom_range(DEPTH_LIMIT - 1, DEPTH_LIMIT + 2) : $urandom_range(0, 3);
        goal   = $urandom_range(1, 10);
        opened = 0;
        nest   = 0;
        atoms  = 0;
        forever begin
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
                emit(unary_ops[$urandom_range(0, 6)]);
                maybe_space();
            end
            if (opened < cap && (deep || $urandom_range(0, 2) == 0)) begin
                emit("(");
                opened++;
                nest++;
                maybe_space();
                continue;
            end
            emit_atom();
            atoms++;
            maybe_space();
            while (nest > 0 && $urandom_range(0, 1) == 0) begin
                emit(")");
                nest--;
                maybe_space();
            end
            if (atoms >= goal) break;
            emit(binary_ops[$urandom_range(0, 10)]);
            maybe_space();
        end
        repeat (nest) emit(")");
    endfunction

    function automatic void queue_text(bit calm_send, bit drain);
        t_char_slot slot;
        for (int i = 0; i < text.size(); i++) begin
            slot.item.character = text[i];
            slot.item.last      = (i == text.size() - 1);
            slot.gap            = calm_send ? 0 : $urandom_range(0, 18);
            slot.drain          = drain && (i == 0);
            char_slots.push_back(slot);
        end
    endfunction

    // sender: present the next character once its gap has run out
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) parse_char(i_item);
            if (!i_valid || !o_stall) begin
                if (char_slots.size() == 0 || (char_slots[0].drain && verdicts_due.size() != 0)) begin
                    i_valid <= 1'b0;
                end else if (char_slots[0].gap > 0) begin
                    char_slots[0].gap = char_slots[0].gap - 1;
                    i_valid <= 1'b0;
                end else begin
                    i_item  <= char_slots[0].item;
                    i_valid <= 1'b1;
                    void'(char_slots.pop_front());
                end
            end
        end
    end

    // receiver: check each verdict transfer, then hold off for a random stretch, save in periodic windows with no hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, got %p", $time, o_result);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("accepted", want.accepted, o_result.accepted);
                    check_field("error_kind", want.error_kind, o_result.error_kind);
                    check_field("error_position", want.error_position, o_result.error_position);
                    check_field("token_count", want.token_count, o_result.token_count);
                end
                hold_left = (((cycles / 2500) % 4) == 1) ? 0 : $urandom_range(0, 18);
            end
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left = hold_left - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int produced;
        int idx;
        foreach (directed[d]) begin
            text.delete();
            emit(directed[d]);
            queue_text(1'b0, 1'b0);
        end
        text = '{8'h00};
        queue_text(1'b0, 1'b0);
        text = '{8'hFF};
        queue_text(1'b0, 1'b0);

        produced = 0;
        for (int f = 0; produced < RANDOM_CHARS; f++) begin
            if ($urandom_range(0, 9) == 0) begin
                text.delete();
                repeat ($urandom_range(1, 8)) text.push_back(pick_byte());
            end else begin
                build_formula();
                if ($urandom_range(0, 3) == 0) begin
                    idx = $urandom_range(0, text.size() - 1);
                    case ($urandom_range(0, 3))
                        0: text[idx] = pick_byte();
                        1: text.insert(idx, pick_byte());
                        2: if (text.size() > 1) text.delete(idx);
                        default: while (text.size() > idx + 1) void'(text.pop_back());
                    endcase
                end
            end
            // the first random formula waits for all earlier verdicts, as does about one in ten of the rest
            queue_text($urandom_range(0, 4) == 0, f == 0 || $urandom_range(0, 9) == 0);
            produced += text.size();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_slots.size() != 0 || i_valid || verdicts_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
